// ----- rtl/core/tmpd_pkg.sv -----
// Shared types and constants for the tape mark pulse decoder.
// Used by tmpd_step and the tape_mark_pulse_decoder top level; no dependencies.
package tmpd_pkg;

    // Result codes carried in the low bits of the result tdata.
    typedef enum logic [1:0] {
        KIND_GOAL    = 2'd0,
        KIND_LEFT    = 2'd1,
        KIND_FORWARD = 2'd2,
        KIND_RIGHT   = 2'd3
    } tape_kind_t;

    // Input operation codes carried in the input tuser.
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_RESUME = 1'b1
    } op_t;

    // Configuration register indexes (byte address divided by four).
    localparam logic [2:0] REG_REFLECT_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_LENGTH_BORDER     = 3'd1;
    localparam logic [2:0] REG_LONG_MARK_LIMIT   = 3'd2;
    localparam logic [2:0] REG_GOAL_GAP_LIMIT    = 3'd3;
    localparam logic [2:0] REG_RELEASE_SAMPLES   = 3'd4;

    localparam logic [7:0]  RST_REFLECT_THRESHOLD = 8'd100;
    localparam logic [15:0] RST_LENGTH_BORDER     = 16'd180;
    localparam logic [15:0] RST_LONG_MARK_LIMIT   = 16'd500;
    localparam logic [15:0] RST_GOAL_GAP_LIMIT    = 16'd300;
    localparam logic [7:0]  RST_RELEASE_SAMPLES   = 8'd10;

    localparam logic [15:0] FLOOR_SAT = 16'd65000;
    localparam logic [15:0] MARK_SAT  = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  reflect_threshold;
        logic [15:0] length_border;
        logic [15:0] long_mark_limit;
        logic [15:0] goal_gap_limit;
        logic [7:0]  release_samples;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        tape_kind_t tape_kind;
        logic       enters_follow;
    } result_t;

endpackage

// ----- rtl/core/tmpd_step.sv -----
// Decoder state and the per-transaction update of mark and floor counters.
// Depends on tmpd_pkg for the configuration and result types.
module tmpd_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  tmpd_pkg::cfg_t    cfg,
    input  logic              fire,
    input  logic              op,
    input  logic [7:0]        sample,
    output tmpd_pkg::result_t result
);
    import tmpd_pkg::*;

    typedef struct packed {
        logic [15:0] mark_length;
        logic [15:0] floor_length;
        logic        over_mark;
        logic        in_pair;
        logic [15:0] first_length;
        logic [7:0]  release_count;
        logic        halted;
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        logic [15:0] mark_inc;
        logic [15:0] floor_inc;
        logic [7:0]  rel_inc;
        logic        a_short;
        logic        b_short;

        state_next             = state_reg;
        result.valid           = 1'b0;
        result.tape_kind       = KIND_GOAL;
        result.enters_follow   = 1'b0;
        mark_inc  = (state_reg.mark_length < MARK_SAT) ?
                    state_reg.mark_length + 16'd1 : state_reg.mark_length;
        floor_inc = (state_reg.floor_length < FLOOR_SAT) ?
                    state_reg.floor_length + 16'd1 : state_reg.floor_length;
        rel_inc   = state_reg.release_count + 8'd1;
        a_short   = state_reg.first_length <= cfg.length_border;
        b_short   = state_reg.mark_length <= cfg.length_border;

        if (fire) begin
            if (op == OP_RESUME) begin
                state_next.halted = 1'b0;
            end else if (!state_reg.halted && sample != 8'd0) begin
                if (sample > cfg.reflect_threshold) begin
                    state_next.over_mark    = 1'b1;
                    state_next.floor_length = '0;
                    state_next.mark_length  = mark_inc;
                    if (mark_inc > cfg.long_mark_limit) begin
                        state_next.in_pair       = 1'b0;
                        state_next.halted        = 1'b1;
                        state_next.mark_length   = '0;
                        result.valid             = 1'b1;
                        result.tape_kind         = KIND_GOAL;
                        result.enters_follow     = 1'b1;
                    end
                end else if (sample < cfg.reflect_threshold) begin
                    if (state_reg.over_mark) begin
                        state_next.release_count = rel_inc;
                        if (rel_inc > cfg.release_samples) begin
                            state_next.release_count = '0;
                            state_next.over_mark     = 1'b0;
                            // A mark of length one is dropped and its count carries on.
                            if (state_reg.mark_length != 16'd1) begin
                                state_next.mark_length = '0;
                                if (state_reg.in_pair) begin
                                    state_next.in_pair = 1'b0;
                                    priority if (state_reg.mark_length == 16'd0) begin
                                        result.valid     = 1'b1;
                                        result.tape_kind = KIND_GOAL;
                                    end else if (a_short && !b_short) begin
                                        result.valid     = 1'b1;
                                        result.tape_kind = KIND_LEFT;
                                    end else if (a_short && b_short) begin
                                        result.valid     = 1'b1;
                                        result.tape_kind = KIND_FORWARD;
                                    end else if (!a_short && b_short) begin
                                        result.valid     = 1'b1;
                                        result.tape_kind = KIND_RIGHT;
                                    end else begin
                                        result.valid     = 1'b0;
                                    end
                                end else begin
                                    state_next.in_pair      = 1'b1;
                                    state_next.first_length = state_reg.mark_length;
                                end
                            end
                        end
                    end else begin
                        state_next.floor_length = floor_inc;
                        if (floor_inc > cfg.goal_gap_limit && state_reg.in_pair) begin
                            state_next.in_pair      = 1'b0;
                            state_next.halted       = 1'b1;
                            state_next.floor_length = '0;
                            result.valid            = 1'b1;
                            result.tape_kind        = KIND_GOAL;
                            result.enters_follow    = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/tape_mark_pulse_decoder.sv -----
// Top level of the tape mark pulse decoder: stream ports, APB register file,
// input and result registers. Depends on tmpd_pkg and tmpd_step.
//
// The decoder takes one reflectance sample per input transaction and sustains
// one transaction per clock cycle while the result side is not stalled. That
// rate is set by the single pass of compare and counter logic in tmpd_step
// between the input register and the result register. A transaction is
// captured in the input register and is decoded once the result register is
// free or is being emptied. Any result is written into the result register
// as it is decoded. While a result waits for m_tready, the input register
// holds at most one transaction and the input side stalls until the result
// leaves. Samples above reflect_threshold lengthen the current mark. Lower
// nonzero samples count toward releasing the mark or toward the goal gap. A
// zero sample, or a sample equal to the threshold, is ignored. After a goal
// with enters_follow set, sample transactions are dropped until a resume
// transaction (tuser high) arrives.
// Registers sit at byte addresses 0 (reflect_threshold), 4 (length_border),
// 8 (long_mark_limit), 12 (goal_gap_limit) and 16 (release_samples), and should
// be written only while no transaction is in flight.
module tape_mark_pulse_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] sample
    input  logic        s_tuser,   // [0] op: 0 sample, 1 resume
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [1:0] tape_kind, [7:2] zero
    output logic        m_tuser,   // [0] enters_follow
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tmpd_pkg::*;

    cfg_t        cfg_reg;
    logic [2:0]  reg_index;

    logic        in_valid_reg;
    logic        in_op_reg;
    logic [7:0]  in_sample_reg;
    logic        in_advance;

    result_t     step_result;
    logic        out_valid_reg;
    tape_kind_t  out_kind_reg;
    logic        out_follow_reg;

    // Register file. pready is tied high, so no access has wait states.
    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reflect_threshold <= RST_REFLECT_THRESHOLD;
            cfg_reg.length_border     <= RST_LENGTH_BORDER;
            cfg_reg.long_mark_limit   <= RST_LONG_MARK_LIMIT;
            cfg_reg.goal_gap_limit    <= RST_GOAL_GAP_LIMIT;
            cfg_reg.release_samples   <= RST_RELEASE_SAMPLES;
        end else if (psel && penable && pwrite) begin
            case (reg_index)
                REG_REFLECT_THRESHOLD: cfg_reg.reflect_threshold <= pwdata[7:0];
                REG_LENGTH_BORDER:     cfg_reg.length_border     <= pwdata[15:0];
                REG_LONG_MARK_LIMIT:   cfg_reg.long_mark_limit   <= pwdata[15:0];
                REG_GOAL_GAP_LIMIT:    cfg_reg.goal_gap_limit    <= pwdata[15:0];
                REG_RELEASE_SAMPLES:   cfg_reg.release_samples   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_REFLECT_THRESHOLD: prdata = {24'd0, cfg_reg.reflect_threshold};
            REG_LENGTH_BORDER:     prdata = {16'd0, cfg_reg.length_border};
            REG_LONG_MARK_LIMIT:   prdata = {16'd0, cfg_reg.long_mark_limit};
            REG_GOAL_GAP_LIMIT:    prdata = {16'd0, cfg_reg.goal_gap_limit};
            REG_RELEASE_SAMPLES:   prdata = {24'd0, cfg_reg.release_samples};
            default:               prdata = 32'd0;
        endcase
    end

    // The held transaction is decoded whenever the result register is free or
    // is being emptied this cycle. Decoding updates the decoder state, so it
    // happens exactly once per accepted transaction.
    assign in_advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !in_valid_reg || in_advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg     <= s_tuser;
            in_sample_reg <= s_tdata;
        end
    end

    tmpd_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .fire    (in_advance),
        .op      (in_op_reg),
        .sample  (in_sample_reg),
        .result  (step_result)
    );

    // Result register. Transactions that produce no result simply leave it
    // empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_advance && step_result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_advance && step_result.valid) begin
            out_kind_reg   <= step_result.tape_kind;
            out_follow_reg <= step_result.enters_follow;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_kind_reg};
    assign m_tuser  = out_follow_reg;

endmodule
